>>> design/pixel_hit_coordinate_mapper_macros.svh
// Assertion macros for the pixel hit coordinate mapper.
// Taken in by the top level, which checks its own pipeline behavior.
`ifndef PIXEL_HIT_COORDINATE_MAPPER_MACROS_SVH
`define PIXEL_HIT_COORDINATE_MAPPER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PHCM_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("phcm: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define PHCM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("phcm: next-cycle check failed");

`endif

>>> design/phcm_pkg.sv
// Shared constants and types of the pixel hit coordinate mapper.
// No dependencies; used by the interfaces and the top level.
`timescale 1ns / 1ps

package phcm_pkg;

  localparam int MAX_COLUMNS_DEFAULT = 4096;
  localparam int MAX_ROWS_DEFAULT    = 4096;

  localparam int POS_W     = 32;
  localparam int INDEX_W   = 14;
  localparam int ID_W      = 24;
  localparam int PITCH_W   = 20;
  localparam int COUNT_W   = 13;
  localparam int SIZE_W    = 30;
  localparam int CFG_DATA_W = 30;
  localparam int CFG_INDEX_W = 3;

  localparam logic [PITCH_W-1:0] PITCH_U_RESET   = 20'd50000;
  localparam logic [PITCH_W-1:0] PITCH_V_RESET   = 20'd50000;
  localparam logic [COUNT_W-1:0] COLUMNS_RESET   = 13'd256;
  localparam logic [COUNT_W-1:0] ROWS_RESET      = 13'd256;
  localparam logic [SIZE_W-1:0]  SIZE_U_RESET    = 30'd12800000;
  localparam logic [SIZE_W-1:0]  SIZE_V_RESET    = 30'd12800000;
  localparam logic [SIZE_W-1:0]  THICKNESS_RESET = 30'd50000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PITCH_U,
    REG_PITCH_V,
    REG_COLUMN_COUNT,
    REG_ROW_COUNT,
    REG_BRICKED,
    REG_SIZE_U,
    REG_SIZE_V,
    REG_THICKNESS
  } cfg_reg_t;

  // Flags that ride alongside the divider stages.
  typedef struct packed {
    logic v_neg;
    logic u_neg;
    logic u_lepu;
    logic sens;
  } side_t;

endpackage

>>> design/phcm_hit_if.sv
// Input channel of the pixel hit coordinate mapper: one hit point per beat.
// Depends on phcm_pkg for the field widths.
`timescale 1ns / 1ps

interface phcm_hit_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [phcm_pkg::POS_W-1:0]     pos_u;
  logic signed [phcm_pkg::POS_W-1:0]     pos_v;
  logic signed [phcm_pkg::POS_W-1:0]     pos_w;

  modport source (output valid, pos_u, pos_v, pos_w, input ready);
  modport sink (input valid, pos_u, pos_v, pos_w, output ready);
endinterface

>>> design/phcm_pixel_if.sv
// Output channel of the pixel hit coordinate mapper: one pixel result per beat.
// Depends on phcm_pkg for the field widths.
`timescale 1ns / 1ps

interface phcm_pixel_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [phcm_pkg::INDEX_W-1:0]   row_index;
  logic signed [phcm_pkg::INDEX_W-1:0]   column_index;
  logic [phcm_pkg::ID_W-1:0]             pixel_id;
  logic                                  pixel_id_valid;
  logic                                  in_sensitive;

  modport source (output valid, row_index, column_index, pixel_id, pixel_id_valid,
                  in_sensitive, input ready);
  modport sink (input valid, row_index, column_index, pixel_id, pixel_id_valid,
                in_sensitive, output ready);
endinterface

>>> design/pixel_hit_coordinate_mapper.sv
// Pixel hit coordinate mapper top level: configuration registers, pipeline, outputs.
// Depends on phcm_pkg, phcm_hit_if, phcm_pixel_if, phcm_div and the macros header.
//
// Usage:
//   hit   : sink channel, one local hit point (pos_u, pos_v, pos_w) per beat.
//   pixel : source channel, one result (row, column, pixel id, flags) per beat.
//   cfg_* : register writes, taken at any edge with cfg_write high; the user must
//           write only while the block holds no item in flight, which the block does not enforce.
// Throughput is one beat per cycle while the receiver takes every beat. The three
// dividers (row, even column, odd column) resolve one quotient bit per stage; the
// other four stages are input register, offset add, clamp and layout select, and
// pixel id multiply-add.
// Reset loads the register defaults and empties the pipeline; no clearing pass.
// When the receiver stalls, the whole pipeline holds and ready on the hit
// channel drops only if the output register is full; no beat is lost or repeated.
`timescale 1ns / 1ps
`include "pixel_hit_coordinate_mapper_macros.svh"

module pixel_hit_coordinate_mapper #(
  parameter int MAX_COLUMNS = phcm_pkg::MAX_COLUMNS_DEFAULT,
  parameter int MAX_ROWS    = phcm_pkg::MAX_ROWS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  phcm_hit_if.sink                            hit,
  phcm_pixel_if.source                        pixel,
  input  logic                                cfg_write,
  input  logic [phcm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [phcm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int PW  = phcm_pkg::PITCH_W;
  localparam int CW  = $clog2(MAX_COLUMNS + 1);
  localparam int RW  = $clog2(MAX_ROWS + 1);
  localparam int QW  = (CW > RW) ? CW : RW;
  localparam int PUW = PW + CW;
  localparam int PVW = PW + RW;
  localparam int PMW = ((PUW > PVW) ? PUW : PVW) + 1;
  localparam int SW  = ((PMW + 1 > 33) ? PMW + 1 : 33) + 2;
  localparam int NW  = SW - 1;
  localparam int IW  = QW + 2;
  localparam int BW  = phcm_pkg::SIZE_W + 1;
  localparam int IDW = CW + QW + 1;
  localparam int L   = QW + 4;

  // Configuration registers.
  logic [PW-1:0]                    pitch_u;
  logic [PW-1:0]                    pitch_v;
  logic [phcm_pkg::COUNT_W-1:0]     column_count;
  logic [phcm_pkg::COUNT_W-1:0]     row_count;
  logic                             bricked;
  logic [phcm_pkg::SIZE_W-1:0]      size_u;
  logic [phcm_pkg::SIZE_W-1:0]      size_v;
  logic [phcm_pkg::SIZE_W-1:0]      thickness;

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_u      <= phcm_pkg::PITCH_U_RESET;
      pitch_v      <= phcm_pkg::PITCH_V_RESET;
      column_count <= phcm_pkg::COLUMNS_RESET;
      row_count    <= phcm_pkg::ROWS_RESET;
      bricked      <= 1'b0;
      size_u       <= phcm_pkg::SIZE_U_RESET;
      size_v       <= phcm_pkg::SIZE_V_RESET;
      thickness    <= phcm_pkg::THICKNESS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        phcm_pkg::REG_PITCH_U:      pitch_u      <= cfg_data[PW-1:0];
        phcm_pkg::REG_PITCH_V:      pitch_v      <= cfg_data[PW-1:0];
        phcm_pkg::REG_COLUMN_COUNT: column_count <= cfg_data[phcm_pkg::COUNT_W-1:0];
        phcm_pkg::REG_ROW_COUNT:    row_count    <= cfg_data[phcm_pkg::COUNT_W-1:0];
        phcm_pkg::REG_BRICKED:      bricked      <= cfg_data[0];
        phcm_pkg::REG_SIZE_U:       size_u       <= cfg_data[phcm_pkg::SIZE_W-1:0];
        phcm_pkg::REG_SIZE_V:       size_v       <= cfg_data[phcm_pkg::SIZE_W-1:0];
        phcm_pkg::REG_THICKNESS:    thickness    <= cfg_data[phcm_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective pitches and counts: zero becomes one, counts clamp to the maxima.
  logic [PW-1:0] pu;
  logic [PW-1:0] pv;
  logic [CW-1:0] ncol;
  logic [RW-1:0] nrow;

  always_comb begin
    pu = (pitch_u == '0) ? PW'(1) : pitch_u;
    pv = (pitch_v == '0) ? PW'(1) : pitch_v;
    if (column_count == '0) begin
      ncol = CW'(1);
    end else if (32'(column_count) > 32'(MAX_COLUMNS)) begin
      ncol = CW'(MAX_COLUMNS);
    end else begin
      ncol = CW'(column_count);
    end
    if (row_count == '0) begin
      nrow = RW'(1);
    end else if (32'(row_count) > 32'(MAX_ROWS)) begin
      nrow = RW'(MAX_ROWS);
    end else begin
      nrow = RW'(row_count);
    end
  end

  logic [L-1:0] vld;
  logic         adv;

  assign adv       = !vld[L-1] || pixel.ready;
  assign hit.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[L-2:0], hit.valid};
    end
  end

  // Stage 1: input register and the offsets of the lower-left corner.
  logic signed [phcm_pkg::POS_W-1:0] s1_u;
  logic signed [phcm_pkg::POS_W-1:0] s1_v;
  logic signed [phcm_pkg::POS_W-1:0] s1_w;
  logic [PMW-1:0]                    s1_off_u;
  logic [PMW-1:0]                    s1_off_uo;
  logic [PMW-1:0]                    s1_off_v;
  logic [BW-1:0]                     s1_bnd_u;
  logic [BW-1:0]                     s1_bnd_v;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_u      <= hit.pos_u;
      s1_v      <= hit.pos_v;
      s1_w      <= hit.pos_w;
      s1_off_u  <= PMW'(ncol * pu);
      s1_off_uo <= PMW'(ncol * pu) + PMW'(pu);
      s1_off_v  <= PMW'(nrow * pv);
      s1_bnd_u  <= BW'(size_u) + BW'(pu);
      s1_bnd_v  <= BW'(size_v) + BW'(pv);
    end
  end

  // Stage 2: doubled coordinates shifted to the corner, sign tests, sensitivity.
  logic signed [SW-1:0] u2;
  logic signed [SW-1:0] u2o;
  logic signed [SW-1:0] v2;
  logic signed [SW-1:0] twice_u;
  logic signed [SW-1:0] twice_v;
  logic signed [SW-1:0] twice_w;
  logic signed [SW-1:0] bu;
  logic signed [SW-1:0] bv;
  logic signed [SW-1:0] bw;
  logic signed [SW-1:0] two_pu;
  phcm_pkg::side_t      side2;

  always_comb begin
    twice_u = $signed({{(SW-phcm_pkg::POS_W-1){s1_u[phcm_pkg::POS_W-1]}}, s1_u, 1'b0});
    twice_v = $signed({{(SW-phcm_pkg::POS_W-1){s1_v[phcm_pkg::POS_W-1]}}, s1_v, 1'b0});
    twice_w = $signed({{(SW-phcm_pkg::POS_W-1){s1_w[phcm_pkg::POS_W-1]}}, s1_w, 1'b0});
    u2      = twice_u + $signed(SW'(s1_off_u));
    u2o     = twice_u + $signed(SW'(s1_off_uo));
    v2      = twice_v + $signed(SW'(s1_off_v));
    bu      = $signed(SW'(s1_bnd_u));
    bv      = $signed(SW'(s1_bnd_v));
    bw      = $signed(SW'(thickness));
    two_pu  = $signed(SW'({pu, 1'b0}));
    side2.v_neg  = v2 <= 0;
    side2.u_neg  = u2 <= 0;
    // u2 <= pu is the same as u2 + pu <= 2 pu.
    side2.u_lepu = u2o <= two_pu;
    side2.sens   = (twice_u >= -bu) && (twice_u <= bu) &&
                   (twice_v >= -bv) && (twice_v <= bv) &&
                   (twice_w >= -bw) && (twice_w <= bw);
  end

  logic [NW-1:0]   s2_nu;
  logic [NW-1:0]   s2_nuo;
  logic [NW-1:0]   s2_nv;
  phcm_pkg::side_t s2_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_nu   <= side2.u_neg  ? '0 : u2[NW-1:0];
      s2_nuo  <= side2.u_lepu ? '0 : u2o[NW-1:0];
      s2_nv   <= side2.v_neg  ? '0 : v2[NW-1:0];
      s2_side <= side2;
    end
  end

  // Divider stages for the row and both column alignments.
  logic [QW-1:0] qv;
  logic [QW-1:0] qe;
  logic [QW-1:0] qo;
  logic          sat_v;
  logic          sat_e;
  logic          sat_o;

  phcm_div #(.NW(NW), .DW(PW + 1), .QW(QW)) u_div_row (
    .clk (clk), .en (adv), .num (s2_nv), .den ({pv, 1'b0}), .quo (qv), .sat (sat_v)
  );

  phcm_div #(.NW(NW), .DW(PW + 1), .QW(QW)) u_div_col_even (
    .clk (clk), .en (adv), .num (s2_nu), .den ({pu, 1'b0}), .quo (qe), .sat (sat_e)
  );

  phcm_div #(.NW(NW), .DW(PW + 1), .QW(QW)) u_div_col_odd (
    .clk (clk), .en (adv), .num (s2_nuo), .den ({pu, 1'b0}), .quo (qo), .sat (sat_o)
  );

  phcm_pkg::side_t sd [QW];

  always_ff @(posedge clk) begin
    if (adv) begin
      sd[0] <= s2_side;
      for (int i = 1; i < QW; i++) begin
        sd[i] <= sd[i-1];
      end
    end
  end

  // Stage 3: clamp the quotients and pick the column of the layout.
  logic signed [IW-1:0] row_c;
  logic signed [IW-1:0] col_c;
  logic signed [IW-1:0] ncol_s;
  logic signed [IW-1:0] nrow_s;
  logic                 row_big;
  logic                 even_big;
  logic                 odd_big;
  phcm_pkg::side_t      side3;

  always_comb begin
    side3    = sd[QW-1];
    ncol_s   = $signed(IW'(ncol));
    nrow_s   = $signed(IW'(nrow));
    row_big  = sat_v || (qv >= QW'(nrow));
    even_big = sat_e || (qe >= QW'(ncol));
    odd_big  = sat_o || (qo >= QW'(ncol));
    if (side3.v_neg) begin
      row_c = '1;
    end else if (row_big) begin
      row_c = nrow_s;
    end else begin
      row_c = $signed(IW'(qv));
    end
    if (!bricked) begin
      if (side3.u_neg) begin
        col_c = '1;
      end else if (even_big) begin
        col_c = ncol_s;
      end else begin
        col_c = $signed(IW'(qe));
      end
    end else if (!row_c[0]) begin
      if (side3.u_neg) begin
        col_c = '0;
      end else if (even_big) begin
        col_c = ncol_s - IW'(1);
      end else begin
        col_c = $signed(IW'(qe));
      end
    end else begin
      // Odd rows, and the row below the matrix, sit half a pitch to the right.
      if (side3.u_lepu) begin
        col_c = '0;
      end else if (odd_big) begin
        col_c = ncol_s - IW'(1);
      end else begin
        col_c = $signed(IW'(qo));
      end
    end
  end

  logic signed [IW-1:0] s3_row;
  logic signed [IW-1:0] s3_col;
  logic                 s3_valid;
  logic                 s3_sens;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_row   <= row_c;
      s3_col   <= col_c;
      s3_valid <= (row_c >= 0) && (row_c < nrow_s) && (col_c >= 0) && (col_c < ncol_s);
      s3_sens  <= side3.sens;
    end
  end

  // Stage 4: linear pixel id and the output register.
  logic [IDW-1:0] id_sum;

  assign id_sum = IDW'(ncol * s3_row[QW-1:0]) + IDW'(s3_col[QW-1:0]);

  always_ff @(posedge clk) begin
    if (adv) begin
      pixel.row_index      <= phcm_pkg::INDEX_W'(s3_row);
      pixel.column_index   <= phcm_pkg::INDEX_W'(s3_col);
      pixel.pixel_id       <= s3_valid ? phcm_pkg::ID_W'(id_sum) : '0;
      pixel.pixel_id_valid <= s3_valid;
      pixel.in_sensitive   <= s3_sens;
    end
  end

  assign pixel.valid = vld[L-1];

  `PHCM_ASSERT_NEXT(a_beat_enters, clk, rst, hit.valid && hit.ready, vld[0])
  `PHCM_ASSERT_IMP(a_id_zero, clk, rst, pixel.valid && !pixel.pixel_id_valid, pixel.pixel_id == '0)
  `PHCM_ASSERT_IMP(a_valid_row, clk, rst, vld[L-2] && s3_valid, !s3_row[IW-1] && !s3_col[IW-1])
  `PHCM_ASSERT_IMP(a_brick_col, clk, rst, vld[L-2] && bricked, !s3_col[IW-1])

endmodule

>>> design/phcm_div.sv
// Pipelined restoring divider, one quotient bit per stage, with saturation flag.
// Standalone; instantiated by the pixel hit coordinate mapper top level.
`timescale 1ns / 1ps

module phcm_div #(
  parameter int NW = 36,
  parameter int DW = 21,
  parameter int QW = 13
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic          sat
);

  localparam int WW = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic [WW-1:0] rem [QW];
  logic [QW-1:0] qt  [QW];
  logic          st  [QW];
  logic [WW-1:0] num_ext;
  logic [WW-1:0] den_ext;

  assign num_ext = WW'(num);
  assign den_ext = WW'(den);

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int K = QW - 1 - s;
    logic [WW-1:0] rem_in;
    logic [QW-1:0] q_in;
    logic [QW-1:0] q_out;
    logic [WW-1:0] dk;
    logic          take;

    always_comb begin
      rem_in = (s == 0) ? num_ext : rem[(s == 0) ? 0 : s - 1];
      q_in   = (s == 0) ? '0 : qt[(s == 0) ? 0 : s - 1];
      dk     = den_ext << K;
      take   = rem_in >= dk;
      q_out    = q_in;
      q_out[K] = take;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s] <= take ? rem_in - dk : rem_in;
        qt[s]  <= q_out;
        if (s == 0) begin
          // A quotient of 2**QW or more is past every count and only saturates.
          st[s] <= num_ext >= (den_ext << QW);
        end else begin
          st[s] <= st[(s == 0) ? 0 : s - 1];
        end
      end
    end
  end

  assign quo = qt[QW-1];
  assign sat = st[QW-1];

endmodule
